[rtl/core/rpn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared widths, token and status codes, and the arithmetic unit's interface
// types.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int DATA_W              = 32;
   localparam int OP_W                = 3;
   localparam int STATUS_W            = 2;
   localparam int CNT_W               = $clog2(DATA_W);
   localparam int DEFAULT_STACK_DEPTH = 64;

   // token codes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

   typedef struct packed {
      logic            start;
      logic [OP_W-1:0] op;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

[rtl/core/rpn_stack_evaluator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates reverse Polish tokens on a stack of signed 32-bit values.
// ----------------------------------------------------------------------------
// One token per transfer; each yields one response with the top value, depth
// and status. A push, an unused code, an underflow or a full stack goes
// straight to the response state. An operator passes through one stack
// memory read, the bit-serial steps of the arithmetic unit, one fix-up step
// and the response state; a divide by zero skips the arithmetic unit. The
// response sits in an output register, so the next token is taken while a
// response still waits. The top of stack is also held in a register; the whole
// stack sits in a single-port-write memory.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_unit #(
   parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH,
   localparam int SP_W       = $clog2(STACK_DEPTH + 1),
   localparam int IDX_W      = $clog2(STACK_DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rpn_pkg::OP_W-1:0]             req_operation,
   input  logic signed [rpn_pkg::DATA_W-1:0]    req_operand,
   input  logic                                 req_start_req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rpn_pkg::DATA_W-1:0]    rsp_top_value,
   output logic [SP_W-1:0]                      rsp_depth,
   output logic [rpn_pkg::STATUS_W-1:0]         rsp_status
);

   localparam int W = rpn_pkg::DATA_W;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EXEC  = 4'b0100,
      S_REPLY = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [SP_W-1:0]                   sp_ff, sp_in;
   logic [W-1:0]                      tos_ff, tos_in;
   logic [rpn_pkg::OP_W-1:0]          op_ff, op_in;
   logic [rpn_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                      rsp_top_ff;
   logic [SP_W-1:0]                   rsp_depth_ff;
   logic [rpn_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic                              rsp_load;

   logic [W-1:0]                      stack_mem [STACK_DEPTH];
   logic [W-1:0]                      rd_ff;
   logic                              rd_en;
   logic [IDX_W-1:0]                  rd_addr;
   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic [W-1:0]                      wr_data;

   logic                              accept;
   logic [SP_W-1:0]                   sp_eff;
   logic [W-1:0]                      tos_eff;
   logic                              is_oper;

   rpn_pkg::alu_req_type              alu_req;
   rpn_pkg::alu_rsp_type              alu_rsp;

   assign accept  = req_valid && !req_stall;
   assign sp_eff  = req_start_req ? '0 : sp_ff;
   assign tos_eff = req_start_req ? '0 : tos_ff;
   assign is_oper = (req_operation == rpn_pkg::OP_ADD) || (req_operation == rpn_pkg::OP_SUB)
                 || (req_operation == rpn_pkg::OP_MUL) || (req_operation == rpn_pkg::OP_DIV);
   assign rd_addr = IDX_W'(sp_eff - SP_W'(2));
   assign rsp_load = (state_ff == S_REPLY) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      sp_in       = sp_ff;
      tos_in      = tos_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = IDX_W'(sp_eff);
      wr_data     = req_operand;
      alu_req     = '0;
      alu_req.op  = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sp_in     = sp_eff;
               tos_in    = tos_eff;
               op_in     = req_operation;
               status_in = rpn_pkg::ST_OK;
               state_in  = S_REPLY;
               priority if (req_operation == rpn_pkg::OP_PUSH) begin
                  if (sp_eff == SP_W'(STACK_DEPTH)) begin
                     status_in = rpn_pkg::ST_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     sp_in  = sp_eff + SP_W'(1);
                     tos_in = req_operand;
                  end
               end else if (is_oper) begin
                  if (sp_eff < SP_W'(2)) begin
                     status_in = rpn_pkg::ST_UNDERFLOW;
                  end else begin
                     // fetch the left operand; the right one is the top register
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  status_in = rpn_pkg::ST_OK;
               end
            end
         end
         S_READ: begin
            if ((op_ff == rpn_pkg::OP_DIV) && (tos_ff == '0)) begin
               status_in = rpn_pkg::ST_DIVZERO;
               state_in  = S_REPLY;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            wr_addr = IDX_W'(sp_ff - SP_W'(2));
            wr_data = alu_rsp.result;
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               sp_in    = sp_ff - SP_W'(1);
               tos_in   = alu_rsp.result;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: load a fresh response or drop a taken one
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         tos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         tos_ff       <= tos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_top_ff    <= tos_ff;
         rsp_depth_ff  <= sp_ff;
         rsp_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= stack_mem[rd_addr];
      end
   end

   rpn_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .left    (rd_ff),
      .right   (tos_ff),
      .alu_rsp (alu_rsp)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[rtl/core/rpn_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN serial arithmetic unit
// Add and subtract one bit per cycle through a carry flop, multiply by
// shift-and-add one multiplier bit per cycle, divide by restoring division
// one quotient bit per cycle. DATA_W steps, then one sign fix-up state.
// ----------------------------------------------------------------------------
module rpn_alu (
   input  logic                             clock,
   input  logic                             reset,
   input  rpn_pkg::alu_req_type             alu_req,
   input  logic [rpn_pkg::DATA_W-1:0]       left,
   input  logic [rpn_pkg::DATA_W-1:0]       right,
   output rpn_pkg::alu_rsp_type             alu_rsp
);

   localparam int W = rpn_pkg::DATA_W;

   typedef enum logic [2:0] {
      A_IDLE = 3'b001,
      A_RUN  = 3'b010,
      A_FIX  = 3'b100
   } alu_state_type;

   alu_state_type                 state_ff, state_in;
   logic [rpn_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rpn_pkg::OP_W-1:0]      op_ff, op_in;
   logic [W-1:0]                  a_ff, a_in;
   logic [W-1:0]                  b_ff, b_in;
   logic [W-1:0]                  acc_ff, acc_in;
   logic [W-1:0]                  rem_ff, rem_in;
   logic                          carry_ff, carry_in;
   logic                          neg_ff, neg_in;
   logic [W:0]                    trial;
   logic                          sum_bit;
   logic [W-1:0                 ] left_mag, right_mag;

   assign left_mag  = left[W-1]  ? (~left + W'(1))  : left;
   assign right_mag = right[W-1] ? (~right + W'(1)) : right;
   assign trial     = {rem_ff, a_ff[W-1]} - {1'b0, b_ff};
   assign sum_bit   = a_ff[0] ^ b_ff[0] ^ carry_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               state_in = A_RUN;
               cnt_in   = '0;
               op_in    = alu_req.op;
               acc_in   = '0;
               rem_in   = '0;
               neg_in   = left[W-1] ^ right[W-1];
               carry_in = (alu_req.op == rpn_pkg::OP_SUB);
               a_in     = (alu_req.op == rpn_pkg::OP_DIV) ? left_mag : left;
               priority if (alu_req.op == rpn_pkg::OP_DIV) begin
                  b_in = right_mag;
               end else if (alu_req.op == rpn_pkg::OP_SUB) begin
                  b_in = ~right;
               end else begin
                  b_in = right;
               end
            end
         end
         A_RUN: begin
            cnt_in = cnt_ff + rpn_pkg::CNT_W'(1);
            if (cnt_ff == rpn_pkg::CNT_W'(W - 1)) begin
               state_in = A_FIX;
            end
            priority if (op_ff == rpn_pkg::OP_MUL) begin
               acc_in = b_ff[0] ? (acc_ff + a_ff) : acc_ff;
               a_in   = {a_ff[W-2:0], 1'b0};
               b_in   = {1'b0, b_ff[W-1:1]};
            end else if (op_ff == rpn_pkg::OP_DIV) begin
               // restore on a negative trial, shift the quotient bit in
               rem_in = trial[W] ? {rem_ff[W-2:0], a_ff[W-1]} : trial[W-1:0];
               a_in   = {a_ff[W-2:0], ~trial[W]};
            end else begin
               acc_in   = {sum_bit, acc_ff[W-1:1]};
               carry_in = (a_ff[0] & b_ff[0]) | (carry_ff & (a_ff[0] ^ b_ff[0]));
               a_in     = {1'b0, a_ff[W-1:1]};
               b_in     = {1'b0, b_ff[W-1:1]};
            end
         end
         A_FIX: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
   end

   always_comb begin
      alu_rsp.done = (state_ff == A_FIX);
      priority if (op_ff == rpn_pkg::OP_DIV) begin
         alu_rsp.result = neg_ff ? (~a_ff + W'(1)) : a_ff;
      end else begin
         alu_rsp.result = acc_ff;
      end
   end

endmodule

[rtl/core/rpn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator port checker
// Watches the evaluator's ports for response consistency over time.
// ----------------------------------------------------------------------------
module rpn_checker #(
   parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH,
   localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rpn_pkg::DATA_W-1:0]        rsp_top_value,
   input logic [SP_W-1:0]                   rsp_depth,
   input logic [rpn_pkg::STATUS_W-1:0]      rsp_status
);

   // hold a stalled response unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_depth) && $stable(rsp_status))
      else $error("stalled response changed");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth <= SP_W'(STACK_DEPTH))
      else $error("depth beyond stack size");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_depth == '0) |-> rsp_top_value == '0)
      else $error("empty stack with nonzero top");

   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rpn_pkg::ST_FULL) |-> rsp_depth == SP_W'(STACK_DEPTH))
      else $error("full status below stack size");

   a_underflow_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rpn_pkg::ST_UNDERFLOW) |-> rsp_depth < SP_W'(2))
      else $error("underflow with two or more entries");

endmodule

bind rpn_stack_evaluator_unit rpn_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_top_value (rsp_top_value),
   .rsp_depth     (rsp_depth),
   .rsp_status    (rsp_status)
);

[bench/tb_rpn_stack_evaluator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator testbench
// Drives reverse Polish token streams into the evaluator and predicts, for
// every token taken, the top value, depth and status it must report. The
// directed tokens cover wrap-around, truncating and overflowing divides,
// divide by zero, underflow, unused codes and a start flag on an operator.
// The random tokens are mostly well-formed expressions, with full-stack
// runs, stray operators and noise mixed in. Source gaps and response
// back-pressure vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator_unit;
   import rpn_pkg::*;

   localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ITEM_TARGET = 1250;
   localparam int TAIL_CYCLES = 50;

   localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;

   // codes the evaluator ignores
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]   top;
      logic [DEPTH_W-1:0]  depth;
      logic [STATUS_W-1:0] status;
   } rpn_result_t;

   class rpn_scoreboard;
      logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
      int unsigned       stack_ptr;
      rpn_result_t       expected_q [$];
      int                errors;

      function new();
         stack_ptr = 0;
         errors    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         if (errors < 100) begin
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
         end
         errors++;
      endtask

      // Apply one token to the shadow stack and queue the response it causes.
      function void note_token(logic [OP_W-1:0] op, logic [DATA_W-1:0] operand,
                               logic start);
         logic [DATA_W-1:0]   lhs;
         logic [DATA_W-1:0]   rhs;
         logic [DATA_W-1:0]   res;
         logic [DATA_W-1:0]   lhs_mag;
         logic [DATA_W-1:0]   rhs_mag;
         logic [STATUS_W-1:0] st;
         rpn_result_t         r;

         st  = ST_OK;
         res = '0;
         if (start) begin
            stack_ptr = 0;
         end
         case (op)
            OP_PUSH: begin
               if (stack_ptr >= STACK_DEPTH) begin
                  st = ST_FULL;
               end else begin
                  stack_mem[stack_ptr] = operand;
                  stack_ptr++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (stack_ptr < 2) begin
                  st = ST_UNDERFLOW;
               end else begin
                  rhs = stack_mem[stack_ptr-1];
                  lhs = stack_mem[stack_ptr-2];
                  case (op)
                     OP_ADD: res = lhs + rhs;
                     OP_SUB: res = lhs - rhs;
                     OP_MUL: res = lhs * rhs;
                     default: begin
                        if (rhs == '0) begin
                           st = ST_DIVZERO;
                        end else begin
                           // divide magnitudes, then restore the sign
                           lhs_mag = lhs[DATA_W-1] ? -lhs : lhs;
                           rhs_mag = rhs[DATA_W-1] ? -rhs : rhs;
                           res     = lhs_mag / rhs_mag;
                           if (lhs[DATA_W-1] ^ rhs[DATA_W-1]) begin
                              res = -res;
                           end
                        end
                     end
                  endcase
                  if (st == ST_OK) begin
                     stack_ptr--;
                     stack_mem[stack_ptr-1] = res;
                  end
               end
            end
            default: ;
         endcase
         r.top    = (stack_ptr > 0) ? stack_mem[stack_ptr-1] : '0;
         r.depth  = DEPTH_W'(stack_ptr);
         r.status = st;
         expected_q.push_back(r);
      endfunction

      task check_response(logic [DATA_W-1:0] top, logic [DEPTH_W-1:0] depth,
                          logic [STATUS_W-1:0] status);
         rpn_result_t want;
         if (expected_q.size() == 0) begin
            report("response with nothing expected", top, '0);
         end else begin
            want = expected_q.pop_front();
            if (top !== want.top) begin
               report("top_value", top, want.top);
            end
            if (depth !== want.depth) begin
               report("depth", DATA_W'(depth), DATA_W'(want.depth));
            end
            if (status !== want.status) begin
               report("status", DATA_W'(status), DATA_W'(want.status));
            end
         end
      endtask
   endclass

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_operation = '0;
   logic signed [DATA_W-1:0]   req_operand   = '0;
   logic                       req_start_req = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic signed [DATA_W-1:0]   rsp_top_value;
   logic [DEPTH_W-1:0]         rsp_depth;
   logic [STATUS_W-1:0]        rsp_status;

   rpn_scoreboard sb = new();
   int            idle_pct   = 0;
   int            stall_pct  = 0;
   int            sent_items = 0;

   rpn_stack_evaluator_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_operand   (req_operand),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Note each token transfer before checking the response of the same edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_token(req_operation, req_operand, req_start_req);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_top_value, rsp_depth, rsp_status);
      end
   end

   function automatic logic [DATA_W-1:0] rand_operand();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return MIN_VAL;
         4:       return MAX_VAL;
         5:       return DATA_W'($urandom_range(32)) - 32'd16;
         default: return $urandom;
      endcase
   endfunction

   // Present one token, hold it until taken, then maybe leave a gap.
   task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand,
                             input logic start);
      req_operation <= op;
      req_operand   <= operand;
      req_start_req <= start;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (op <= OP_DIV) begin
         sent_items++;
      end
      if ($urandom_range(99) < idle_pct) begin
         req_valid     <= 1'b0;
         req_operation <= OP_W'($urandom);
         req_operand   <= $urandom;
         req_start_req <= 1'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_operator(input logic start);
      send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), $urandom, start);
   endtask

   // Well-formed expression; optionally one stray operator at the end.
   task automatic send_expression(input bit with_start, input bit add_stray);
      int n_opnd;
      int pushed;
      int live;
      bit first;
      n_opnd = $urandom_range(2, 9);
      pushed = 0;
      live   = 0;
      first  = with_start;
      while (pushed < n_opnd || live > 1) begin
         if (pushed < n_opnd && (live < 2 || $urandom_range(1) == 0)) begin
            send_token(OP_PUSH, rand_operand(), first);
            pushed++;
            live++;
         end else begin
            send_operator(first);
            live--;
         end
         first = 1'b0;
      end
      if (add_stray) begin
         send_operator(1'b0);
      end
   endtask

   // Fill the stack, push past the top, then reduce a little and push again.
   task automatic fill_stack();
      send_token(OP_PUSH, rand_operand(), 1'b1);
      repeat (STACK_DEPTH - 1) send_token(OP_PUSH, rand_operand(), 1'b0);
      repeat ($urandom_range(1, 3)) send_token(OP_PUSH, rand_operand(), 1'b0);
      repeat ($urandom_range(1, 12)) send_operator(1'b0);
      send_token(OP_PUSH, rand_operand(), 1'b0);
   endtask

   initial begin
      int phase_idle [4];
      int phase_stall [4];
      int kind;
      phase_idle  = '{0, 61, 0, 31};
      phase_stall = '{0, 0, 61, 31};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed tokens
      send_token(OP_ADD, $urandom, 1'b0);
      send_token(OP_PUSH, MAX_VAL, 1'b1);
      send_token(OP_PUSH, 32'd1, 1'b0);
      send_token(OP_ADD, $urandom, 1'b0);
      send_token(OP_PUSH, 32'd1, 1'b0);
      send_token(OP_SUB, $urandom, 1'b0);
      send_token(OP_PUSH, '0, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      send_token(OP_PUSH, MIN_VAL, 1'b1);
      send_token(OP_PUSH, '1, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      send_token(OP_PUSH, 32'd7, 1'b1);
      send_token(OP_PUSH, -32'sd2, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      send_token(OP_PUSH, -32'sd7, 1'b0);
      send_token(OP_PUSH, 32'd2, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      send_token(OP_PUSH, 32'h9ABC_DEF0, 1'b0);
      send_token(OP_MUL, $urandom, 1'b0);
      for (int code = OP_UNUSED_LO; code <= OP_UNUSED_HI; code++) begin
         send_token(OP_W'(code), $urandom, code == OP_UNUSED_HI);
      end
      send_token(OP_MUL, $urandom, 1'b1);

      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         fill_stack();
         while (sent_items < (ITEM_TARGET * (p + 1)) / 4) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
               send_expression(1'b1, 1'b0);
            end else if (kind < 80) begin
               send_expression(1'b0, 1'b0);
            end else if (kind < 88) begin
               send_expression(1'b1, 1'b1);
            end else if (kind < 97) begin
               repeat ($urandom_range(1, 4)) begin
                  send_token(OP_W'($urandom), $urandom, $urandom_range(7) == 0);
               end
            end else begin
               fill_stack();
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
